>>> src/jts_pkg.sv
// Shared types, codes and lookup functions for the JSON token scanner.
package jts_pkg;

  localparam int unsigned MAX_TEXT_BYTES_DEF = 65536;
  localparam int unsigned MAX_RESULTS        = 3;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LBRACK = 4'd2;
  localparam logic [3:0] KIND_RBRACK = 4'd3;
  localparam logic [3:0] KIND_COLON  = 4'd4;
  localparam logic [3:0] KIND_COMMA  = 4'd5;
  localparam logic [3:0] KIND_NULL   = 4'd6;
  localparam logic [3:0] KIND_STRING = 4'd9;
  localparam logic [3:0] KIND_NUMBER = 4'd10;
  localparam logic [3:0] KIND_END    = 4'd11;

  localparam logic [2:0] STATUS_TOKEN_OK     = 3'd0;
  localparam logic [2:0] STATUS_END_OK       = 3'd1;
  localparam logic [2:0] STATUS_BAD_LITERAL  = 3'd2;
  localparam logic [2:0] STATUS_UNBALANCED   = 3'd3;
  localparam logic [2:0] STATUS_UNTERMINATED = 3'd4;

  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] seen;
    logic [2:0]  status;
  } jts_rec_t;

  // all results caused by one byte; cnt is 1..3 when queued
  typedef struct packed {
    jts_rec_t [MAX_RESULTS-1:0] rec;
    logic [1:0]                 cnt;
  } jts_bundle_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case ({which, pos})
      {LIT_NULL, 3'd0}:  ch = 8'h6E;
      {LIT_NULL, 3'd1}:  ch = 8'h75;
      {LIT_NULL, 3'd2}:  ch = 8'h6C;
      {LIT_NULL, 3'd3}:  ch = 8'h6C;
      {LIT_TRUE, 3'd0}:  ch = 8'h74;
      {LIT_TRUE, 3'd1}:  ch = 8'h72;
      {LIT_TRUE, 3'd2}:  ch = 8'h75;
      {LIT_TRUE, 3'd3}:  ch = 8'h65;
      {LIT_FALSE, 3'd0}: ch = 8'h66;
      {LIT_FALSE, 3'd1}: ch = 8'h61;
      {LIT_FALSE, 3'd2}: ch = 8'h6C;
      {LIT_FALSE, 3'd3}: ch = 8'h73;
      {LIT_FALSE, 3'd4}: ch = 8'h65;
      default:           ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] which);
    return (which == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

>>> src/jts_front.sv
// Front end: per-byte lexer state machine, builds the result bundle of each byte.
module jts_front #(
  parameter int unsigned MAX_TEXT_BYTES = jts_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          text_byte_i,
  input  logic                final_byte_i,
  output jts_pkg::jts_bundle_t bundle_o
);

  localparam int unsigned PW = $clog2(MAX_TEXT_BYTES);
  localparam int unsigned XW = (PW >= 16) ? PW + 2 : 18;

  localparam logic [3:0] MODE_IDLE       = 4'd0;
  localparam logic [3:0] MODE_STRING     = 4'd1;
  localparam logic [3:0] MODE_ESCAPE     = 4'd2;
  localparam logic [3:0] MODE_LITERAL    = 4'd3;
  localparam logic [3:0] MODE_NUMBER     = 4'd4;
  localparam logic [3:0] MODE_SLASH      = 4'd5;
  localparam logic [3:0] MODE_LINE       = 4'd6;
  localparam logic [3:0] MODE_BLOCK      = 4'd7;
  localparam logic [3:0] MODE_BLOCK_STAR = 4'd8;

  logic [3:0]         mode_q, mode_d;
  logic [1:0]         lit_which_q, lit_which_d;
  logic [2:0]         lit_pos_q, lit_pos_d;
  logic [PW-1:0]      start_q, start_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic signed [16:0] bal_q, bal_d;
  logic [15:0]        total_q, total_d;

  logic [PW:0]        diff;
  logic [PW-1:0]      sp;
  logic [XW-1:0]      sp_x, sp1_x, pos_x, pos1_x, start_x;
  logic [15:0]        len_sp, len_sp1, len_end;
  logic [15:0]        start16, pos16;
  logic               is_num;
  logic [2:0]         lit_pos_inc;

  function automatic logic [15:0] sat16(input logic [XW-1:0] v);
    return (v > XW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  // span from token start to current byte, modulo text size
  always_comb begin
    diff    = {1'b0, pos_q} - {1'b0, start_q};
    sp      = diff[PW] ? PW'(diff + (PW+1)'(MAX_TEXT_BYTES)) : diff[PW-1:0];
    sp_x    = XW'(sp);
    sp1_x   = sp_x + XW'(1);
    pos_x   = XW'(pos_q);
    pos1_x  = pos_x + XW'(1);
    start_x = XW'(start_q);
    len_sp  = sat16(sp_x);
    len_sp1 = sat16(sp1_x);
    len_end = sat16(pos1_x);
    start16 = start_x[15:0];
    pos16   = pos_x[15:0];
    is_num  = (text_byte_i inside {[8'h30:8'h39], 8'h2E});
    lit_pos_inc = lit_pos_q + 3'd1;
  end

  jts_pkg::jts_bundle_t bnd;
  logic [1:0]  cnt;
  logic [15:0] tot;
  logic        do_start;
  logic        num_cont;
  logic [2:0]  end_status;

  always_comb begin
    mode_d      = mode_q;
    lit_which_d = lit_which_q;
    lit_pos_d   = lit_pos_q;
    start_d     = start_q;
    pos_d       = pos_q;
    bal_d       = bal_q;
    tot         = total_q;
    bnd         = '0;
    cnt         = 2'd0;
    do_start    = 1'b0;
    end_status  = jts_pkg::STATUS_END_OK;

    case (mode_q)
      MODE_STRING: begin
        if (text_byte_i == 8'h5C) begin
          mode_d = MODE_ESCAPE;
        end else if (text_byte_i == 8'h22) begin
          tot = jts_pkg::sat_inc16(tot);
          bnd.rec[cnt] = '{kind: jts_pkg::KIND_STRING, offset: start16, length: len_sp1,
                           seen: tot, status: jts_pkg::STATUS_TOKEN_OK};
          cnt = cnt + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_ESCAPE: mode_d = MODE_STRING;
      MODE_LITERAL: begin
        if (text_byte_i == jts_pkg::lit_char(lit_which_q, lit_pos_q)) begin
          lit_pos_d = lit_pos_inc;
          if (lit_pos_inc == jts_pkg::lit_len(lit_which_q)) begin
            tot = jts_pkg::sat_inc16(tot);
            bnd.rec[cnt] = '{kind: jts_pkg::KIND_NULL + {2'b00, lit_which_q}, offset: start16,
                             length: 16'(jts_pkg::lit_len(lit_which_q)), seen: tot,
                             status: jts_pkg::STATUS_TOKEN_OK};
            cnt = cnt + 2'd1;
            mode_d    = MODE_IDLE;
            lit_pos_d = 3'd0;
          end
        end else begin
          // bad literal: reported, not counted, byte rescanned
          bnd.rec[cnt] = '{kind: jts_pkg::KIND_NULL + {2'b00, lit_which_q}, offset: start16,
                           length: 16'(lit_pos_q), seen: tot,
                           status: jts_pkg::STATUS_BAD_LITERAL};
          cnt = cnt + 2'd1;
          lit_pos_d = 3'd0;
          do_start  = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!is_num) begin
          tot = jts_pkg::sat_inc16(tot);
          bnd.rec[cnt] = '{kind: jts_pkg::KIND_NUMBER, offset: start16, length: len_sp,
                           seen: tot, status: jts_pkg::STATUS_TOKEN_OK};
          cnt = cnt + 2'd1;
          do_start = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (text_byte_i == 8'h2F)      mode_d = MODE_LINE;
        else if (text_byte_i == 8'h2A) mode_d = MODE_BLOCK;
        else                           do_start = 1'b1;
      end
      MODE_LINE: begin
        if (text_byte_i == 8'h0A) mode_d = MODE_IDLE;
      end
      MODE_BLOCK: begin
        if (text_byte_i == 8'h2A) mode_d = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (text_byte_i == 8'h2F)      mode_d = MODE_IDLE;
        else if (text_byte_i != 8'h2A) mode_d = MODE_BLOCK;
      end
      default: do_start = 1'b1;
    endcase

    if (do_start) begin
      mode_d = MODE_IDLE;
      case (text_byte_i)
        8'h7B, 8'h5B: begin
          if (bal_q != 17'sh0FFFF) bal_d = bal_q + 17'sd1;
          tot = jts_pkg::sat_inc16(tot);
          bnd.rec[cnt] = '{kind: (text_byte_i == 8'h7B) ? jts_pkg::KIND_LBRACE
                                                       : jts_pkg::KIND_LBRACK,
                           offset: pos16, length: 16'd1, seen: tot,
                           status: jts_pkg::STATUS_TOKEN_OK};
          cnt = cnt + 2'd1;
        end
        8'h7D, 8'h5D: begin
          if (bal_q != -17'sd65536) bal_d = bal_q - 17'sd1;
          tot = jts_pkg::sat_inc16(tot);
          bnd.rec[cnt] = '{kind: (text_byte_i == 8'h7D) ? jts_pkg::KIND_RBRACE
                                                       : jts_pkg::KIND_RBRACK,
                           offset: pos16, length: 16'd1, seen: tot,
                           status: jts_pkg::STATUS_TOKEN_OK};
          cnt = cnt + 2'd1;
        end
        8'h3A, 8'h2C: begin
          tot = jts_pkg::sat_inc16(tot);
          bnd.rec[cnt] = '{kind: (text_byte_i == 8'h3A) ? jts_pkg::KIND_COLON
                                                       : jts_pkg::KIND_COMMA,
                           offset: pos16, length: 16'd1, seen: tot,
                           status: jts_pkg::STATUS_TOKEN_OK};
          cnt = cnt + 2'd1;
        end
        8'h6E, 8'h74, 8'h66: begin
          lit_which_d = (text_byte_i == 8'h6E) ? jts_pkg::LIT_NULL :
                        (text_byte_i == 8'h74) ? jts_pkg::LIT_TRUE : jts_pkg::LIT_FALSE;
          lit_pos_d = 3'd1;
          start_d   = pos_q;
          mode_d    = MODE_LITERAL;
        end
        8'h22: begin
          start_d = pos_q;
          mode_d  = MODE_STRING;
        end
        8'h2F: mode_d = MODE_SLASH;
        default: begin
          if (is_num) begin
            start_d = pos_q;
            mode_d  = MODE_NUMBER;
          end
        end
      endcase
    end

    num_cont = (mode_q == MODE_NUMBER) && !do_start;

    if (final_byte_i) begin
      if (mode_d == MODE_NUMBER) begin
        tot = jts_pkg::sat_inc16(tot);
        bnd.rec[cnt] = '{kind: jts_pkg::KIND_NUMBER, offset: start16,
                         length: num_cont ? len_sp1 : 16'd1, seen: tot,
                         status: jts_pkg::STATUS_TOKEN_OK};
        if (!num_cont) bnd.rec[cnt].offset = pos16;
        cnt = cnt + 2'd1;
      end
      if (mode_d == MODE_STRING || mode_d == MODE_ESCAPE) begin
        end_status = jts_pkg::STATUS_UNTERMINATED;
      end else if (mode_d == MODE_LITERAL) begin
        end_status = jts_pkg::STATUS_BAD_LITERAL;
      end else if (bal_d != 17'sd0) begin
        end_status = jts_pkg::STATUS_UNBALANCED;
      end
      bnd.rec[cnt] = '{kind: jts_pkg::KIND_END, offset: pos16, length: len_end,
                       seen: tot, status: end_status};
      cnt = cnt + 2'd1;
      // back to reset state for the next text
      mode_d      = MODE_IDLE;
      lit_which_d = 2'd0;
      lit_pos_d   = 3'd0;
      start_d     = '0;
      pos_d       = '0;
      bal_d       = '0;
      tot         = 16'd0;
    end else begin
      pos_d = (pos_q == PW'(MAX_TEXT_BYTES - 1)) ? '0 : pos_q + PW'(1);
    end

    total_d = tot;
    bnd.cnt = cnt;
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      lit_which_q <= 2'd0;
      lit_pos_q   <= 3'd0;
      start_q     <= '0;
      pos_q       <= '0;
      bal_q       <= '0;
      total_q     <= 16'd0;
    end else if (accept_i) begin
      mode_q      <= mode_d;
      lit_which_q <= lit_which_d;
      lit_pos_q   <= lit_pos_d;
      start_q     <= start_d;
      pos_q       <= pos_d;
      bal_q       <= bal_d;
      total_q     <= total_d;
    end
  end

endmodule

>>> src/jts_queue.sv
// Short bundle queue between the lexer front end and the result back end.
module jts_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jts_pkg::jts_bundle_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output jts_pkg::jts_bundle_t data_o
);

  localparam int unsigned AW = $clog2(jts_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(jts_pkg::QUEUE_DEPTH + 1);

  jts_pkg::jts_bundle_t mem_q [jts_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(jts_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(jts_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(jts_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop)      count_q <= count_q + CW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CW'(1);
    end
  end

endmodule

>>> src/jts_back.sv
// Back end: unpacks queued bundles into single result beats behind an output register.
module jts_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  jts_pkg::jts_bundle_t q_data_i,
  output logic                 q_pop_o,
  output jts_pkg::jts_rec_t    rec_o,
  output logic                 last_o,
  output logic                 empty_o,
  input  logic                 pop_i
);

  logic              valid_q;
  jts_pkg::jts_rec_t rec_q;
  logic              last_q;
  logic [1:0]        idx_q;
  logic              take, is_last;

  assign take    = !q_empty_i && (!valid_q || pop_i);
  assign is_last = (idx_q == q_data_i.cnt - 2'd1);
  assign q_pop_o = take && is_last;

  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_q  <= q_data_i.rec[idx_q];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (take)       valid_q <= 1'b1;
      else if (pop_i) valid_q <= 1'b0;
      if (take) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  assign rec_o   = rec_q;
  assign last_o  = last_q;
  assign empty_o = !valid_q;

endmodule

>>> src/json_token_scanner_core.sv
// Path: a byte's results pass the bundle queue, then the output register.
// Throughput: one byte per cycle while the queue is not full; results leave one
// per cycle while pop is held, the 4-bundle queue absorbing bursts.
// Reset: asynchronous, clears lexer state, counters and queue; no clearing pass.
// Top level: JSON token scanner with queue-style input and result ports.
module json_token_scanner_core #(
  parameter int unsigned MAX_TEXT_BYTES = jts_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        final_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] tokens_seen_o,
  output logic [2:0]  scan_status_o,
  output logic        run_last_o
);

  jts_pkg::jts_bundle_t fr_bundle, q_data;
  jts_pkg::jts_rec_t    out_rec;
  logic                 accept, q_push, q_full, q_empty, q_pop;

  assign accept = push && !full;
  assign q_push = accept && (fr_bundle.cnt != 2'd0);
  assign full   = q_full;

  jts_front #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .final_byte_i(final_byte_i),
    .bundle_o    (fr_bundle)
  );

  jts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (fr_bundle),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_data)
  );

  jts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_data),
    .q_pop_o  (q_pop),
    .rec_o    (out_rec),
    .last_o   (run_last_o),
    .empty_o  (empty),
    .pop_i    (pop)
  );

  assign token_kind_o   = out_rec.kind;
  assign token_offset_o = out_rec.offset;
  assign token_length_o = out_rec.length;
  assign tokens_seen_o  = out_rec.seen;
  assign scan_status_o  = out_rec.status;

endmodule

>>> src/jts_checker.sv
// Port-level checker for the JSON token scanner, bound to the top level.
module jts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  token_kind_o,
  input logic [15:0] token_offset_o,
  input logic [15:0] token_length_o,
  input logic [15:0] tokens_seen_o,
  input logic [2:0]  scan_status_o,
  input logic        run_last_o
);

  // a result beat not taken stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(token_kind_o) && $stable(token_offset_o)
      && $stable(token_length_o) && $stable(tokens_seen_o) && $stable(scan_status_o))
    else $error("result changed while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && token_kind_o == jts_pkg::KIND_END |-> run_last_o)
    else $error("end result not last of its byte");

  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (scan_status_o == jts_pkg::STATUS_END_OK
      || scan_status_o == jts_pkg::STATUS_UNBALANCED
      || scan_status_o == jts_pkg::STATUS_UNTERMINATED)
    |-> token_kind_o == jts_pkg::KIND_END)
    else $error("end status on a non-end result");

  a_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && token_kind_o != jts_pkg::KIND_END
      && scan_status_o == jts_pkg::STATUS_TOKEN_OK |-> tokens_seen_o != 16'd0)
    else $error("good token with zero count");

endmodule

bind json_token_scanner_core jts_checker u_jts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .token_kind_o  (token_kind_o),
  .token_offset_o(token_offset_o),
  .token_length_o(token_length_o),
  .tokens_seen_o (tokens_seen_o),
  .scan_status_o (scan_status_o),
  .run_last_o    (run_last_o)
);
